FILE: design/md4_hash_engine_macros.svh
`ifndef MD4_HASH_ENGINE_MACROS_SVH
`define MD4_HASH_ENGINE_MACROS_SVH

`ifndef SYNTH
`define MD4_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MD4_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MD4_ASSERT_IMPL(name, ante, cons, msg)
`define MD4_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

FILE: design/md4_pkg.sv
package md4_pkg;

    localparam int CNT_W = 61;
    localparam int PC_W  = 4;

    localparam logic [31:0] MD4_IV [4] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476
    };
    localparam logic [31:0] MD4_K2 = 32'h5A827999;
    localparam logic [31:0] MD4_K3 = 32'h6ED9EBA1;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LEN_POS = 6'd56;
    localparam logic [5:0]  LAST_POS = 6'd63;
    localparam logic [5:0]  LAST_ROUND = 6'd47;
    localparam logic [3:0]  LEN_LO_WORD = 4'd14;
    localparam logic [3:0]  LEN_HI_WORD = 4'd15;

    typedef enum logic [3:0] {
        OP_IDLE, OP_NONE, OP_LOAD, OP_ROUND, OP_ADD, OP_PADB,
        OP_ZERO, OP_WCLR, OP_LEN_LO, OP_LEN_HI, OP_EMIT, OP_INIT
    } op_t;

    typedef enum logic [2:0] {
        NX_NEXT, NX_JUMP, NX_BRANCH, NX_STAY, NX_CALL, NX_RET, NX_DISPATCH
    } nx_t;

    typedef enum logic [2:0] {
        C_ALWAYS, C_ROUND_MORE, C_WORD_MORE, C_NO_END, C_POS_LOW, C_EMIT_MORE
    } cond_t;

    typedef struct packed {
        op_t             op;
        nx_t             nx;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic accept;
        logic byte_in;
        logic end_in;
        logic pos_last;
        logic end_pend;
        logic pos_low;
        logic round_more;
        logic word_more;
        logic emit_more;
    } md4_status_t;

    localparam logic [PC_W-1:0] A_IDLE  = 4'd0;
    localparam logic [PC_W-1:0] A_LOAD  = 4'd1;
    localparam logic [PC_W-1:0] A_ROUND = 4'd2;
    localparam logic [PC_W-1:0] A_ADD   = 4'd3;
    localparam logic [PC_W-1:0] A_AFTER = 4'd4;
    localparam logic [PC_W-1:0] A_PADB  = 4'd5;
    localparam logic [PC_W-1:0] A_PADZ  = 4'd6;
    localparam logic [PC_W-1:0] A_CHECK = 4'd7;
    localparam logic [PC_W-1:0] A_EXTRA = 4'd8;
    localparam logic [PC_W-1:0] A_CLEAR = 4'd9;
    localparam logic [PC_W-1:0] A_LENLO = 4'd10;
    localparam logic [PC_W-1:0] A_LENHI = 4'd11;
    localparam logic [PC_W-1:0] A_EMIT  = 4'd12;
    localparam logic [PC_W-1:0] A_INIT  = 4'd13;

    // Each control word names the datapath operation and how the step counter moves.
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] addr);
        ucode_t w;
        unique case (addr)
            A_IDLE:  w = '{OP_IDLE,   NX_DISPATCH, C_ALWAYS,     A_AFTER};
            A_LOAD:  w = '{OP_LOAD,   NX_NEXT,     C_ALWAYS,     A_IDLE};
            A_ROUND: w = '{OP_ROUND,  NX_STAY,     C_ROUND_MORE, A_IDLE};
            A_ADD:   w = '{OP_ADD,    NX_RET,      C_ALWAYS,     A_IDLE};
            A_AFTER: w = '{OP_NONE,   NX_BRANCH,   C_NO_END,     A_IDLE};
            A_PADB:  w = '{OP_PADB,   NX_NEXT,     C_ALWAYS,     A_IDLE};
            A_PADZ:  w = '{OP_ZERO,   NX_STAY,     C_WORD_MORE,  A_IDLE};
            A_CHECK: w = '{OP_NONE,   NX_BRANCH,   C_POS_LOW,    A_LENLO};
            A_EXTRA: w = '{OP_WCLR,   NX_CALL,     C_ALWAYS,     A_CLEAR};
            A_CLEAR: w = '{OP_ZERO,   NX_STAY,     C_WORD_MORE,  A_IDLE};
            A_LENLO: w = '{OP_LEN_LO, NX_NEXT,     C_ALWAYS,     A_IDLE};
            A_LENHI: w = '{OP_LEN_HI, NX_CALL,     C_ALWAYS,     A_EMIT};
            A_EMIT:  w = '{OP_EMIT,   NX_STAY,     C_EMIT_MORE,  A_IDLE};
            A_INIT:  w = '{OP_INIT,   NX_JUMP,     C_ALWAYS,     A_IDLE};
            default: w = '{OP_NONE,   NX_JUMP,     C_ALWAYS,     A_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] idx;
        unique case (r[5:4])
            2'd0:    idx = r[3:0];
            2'd1:    idx = {r[1:0], r[3:2]};
            default: idx = {r[0], r[1], r[2], r[3]};
        endcase
        return idx;
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] r);
        logic [4:0] s;
        unique case ({r[5:4], r[1:0]})
            4'h0: s = 5'd3;
            4'h1: s = 5'd7;
            4'h2: s = 5'd11;
            4'h3: s = 5'd19;
            4'h4: s = 5'd3;
            4'h5: s = 5'd5;
            4'h6: s = 5'd9;
            4'h7: s = 5'd13;
            4'h8: s = 5'd3;
            4'h9: s = 5'd9;
            4'hA: s = 5'd11;
            4'hB: s = 5'd15;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

endpackage

FILE: design/md4_seq.sv
module md4_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  md4_pkg::md4_status_t status,
    output md4_pkg::op_t         op
);
    import md4_pkg::*;

    logic [PC_W-1:0] pc_reg, pc_next;
    logic [PC_W-1:0] ret_reg, ret_next;
    ucode_t          cw;
    logic            cond_true;

    assign cw = ucode_rom(pc_reg);
    assign op = cw.op;

    always_comb
    begin
        unique case (cw.cond)
            C_ALWAYS:     cond_true = 1'b1;
            C_ROUND_MORE: cond_true = status.round_more;
            C_WORD_MORE:  cond_true = status.word_more;
            C_NO_END:     cond_true = !status.end_pend;
            C_POS_LOW:    cond_true = status.pos_low;
            C_EMIT_MORE:  cond_true = status.emit_more;
            default:      cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        pc_next  = pc_reg;
        ret_next = ret_reg;
        unique case (cw.nx)
            NX_NEXT:   pc_next = pc_reg + 1'b1;
            NX_JUMP:   pc_next = cw.target;
            NX_BRANCH: pc_next = cond_true ? cw.target : pc_reg + 1'b1;
            NX_STAY:   pc_next = cond_true ? pc_reg : pc_reg + 1'b1;
            NX_CALL:
            begin
                pc_next  = A_LOAD;
                ret_next = cw.target;
            end
            NX_RET:    pc_next = ret_reg;
            NX_DISPATCH:
            begin
                if (status.accept && status.byte_in && status.pos_last)
                begin
                    pc_next  = A_LOAD;
                    ret_next = cw.target;
                end
                else if (status.accept && status.end_in)
                begin
                    pc_next = A_PADB;
                end
            end
            default:   pc_next = A_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= A_IDLE;
            ret_reg <= A_IDLE;
        end
        else
        begin
            pc_reg  <= pc_next;
            ret_reg <= ret_next;
        end
    end

endmodule

FILE: design/md4_hash_engine.sv
// MD4 digest engine for a byte stream.
// The input stream carries one request per cycle at most: tdata holds a message byte,
// tuser says whether that byte is present, and tlast closes the message.
// The output stream returns the four digest words, word_index in tuser, tlast on word 3.
// A byte that neither completes a 64-byte block nor closes the message leaves the engine idle.
// The byte that completes a block holds tready low while the single round unit runs
// the 48 rounds, one per cycle, and adds into the chaining words.
// Closing a message takes the padding sweep, one or two compressions with a block
// clear between them, and the hand-out of the four digest words, plus one more
// compression before the padding when the closing request also completes a block.
// The output words sit in a register stage; while the receiver stalls, the engine
// waits with the next word and accepts no input until the last word is loaded.
// Reset restores the MD4 initial chaining values and clears the byte count;
// the engine comes out of reset in its idle state, ready for input.
`include "md4_hash_engine_macros.svh"

module md4_hash_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic [0:0]  s_axis_tuser,   // byte_present
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word
    output logic [1:0]  m_axis_tuser,   // word_index
    output logic        m_axis_tlast
);
    import md4_pkg::*;

    op_t               op;
    md4_status_t       status;

    logic [31:0]       chain_reg [4];
    logic [31:0]       chain_next [4];
    logic [31:0]       blk_reg [16];
    logic [31:0]       a_reg, b_reg, c_reg, d_reg;
    logic [31:0]       a_next, b_next, c_next, d_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [5:0]        round_reg, round_next;
    logic [4:0]        wcnt_reg, wcnt_next;
    logic              end_pend_reg, end_pend_next;
    logic [1:0]        oidx_reg, oidx_next;
    logic              out_valid_reg, out_valid_next;
    logic [31:0]       word_reg, word_next;
    logic [1:0]        idx_reg, idx_next;
    logic              last_reg, last_next;

    logic              in_acc;
    logic              emit_load;
    logic [3:0]        pos_word;
    logic [1:0]        lane;
    logic [31:0]       f_val;
    logic [31:0]       round_sum;
    logic [63:0]       rot_wide;
    logic [31:0]       rot_val;

    logic              wr_en;
    logic [3:0]        wr_addr;
    logic [31:0]       wr_data;
    logic [3:0]        wr_mask;

    md4_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .op     (op)
    );

    assign s_axis_tready = (op == OP_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign emit_load     = (op == OP_EMIT) && (!out_valid_reg || m_axis_tready);
    assign pos_word      = cnt_reg[5:2];
    assign lane          = cnt_reg[1:0];

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = word_reg;
    assign m_axis_tuser  = idx_reg;
    assign m_axis_tlast  = last_reg;

    always_comb
    begin
        status.accept     = in_acc;
        status.byte_in    = s_axis_tuser[0];
        status.end_in     = s_axis_tlast;
        status.pos_last   = (cnt_reg[5:0] == LAST_POS);
        status.end_pend   = end_pend_reg;
        status.pos_low    = (cnt_reg[5:0] < LEN_POS);
        status.round_more = (round_reg != LAST_ROUND);
        status.word_more  = (wcnt_reg < 5'd15);
        status.emit_more  = !(emit_load && (oidx_reg == 2'd3));
    end

    always_comb
    begin
        unique case (round_reg[5:4])
            2'd0:    f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1:    f_val = ((b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg)) + MD4_K2;
            default: f_val = (b_reg ^ c_reg ^ d_reg) + MD4_K3;
        endcase
        round_sum = a_reg + f_val + blk_reg[msg_index(round_reg)];
        rot_wide  = {round_sum, round_sum} << rot_amount(round_reg);
        rot_val   = rot_wide[63:32];
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pos_word;
        wr_data = '0;
        wr_mask = '0;
        unique case (op)
            OP_IDLE:
            begin
                wr_en   = in_acc && s_axis_tuser[0];
                wr_data = {4{s_axis_tdata}};
                wr_mask = 4'b0001 << lane;
            end
            OP_PADB:
            begin
                wr_en   = 1'b1;
                wr_data = {24'd0, PAD_BYTE} << {lane, 3'b000};
                wr_mask = 4'b1111 << lane;
            end
            OP_ZERO:
            begin
                wr_en   = !wcnt_reg[4];
                wr_addr = wcnt_reg[3:0];
                wr_mask = 4'b1111;
            end
            OP_LEN_LO:
            begin
                wr_en   = 1'b1;
                wr_addr = LEN_LO_WORD;
                wr_data = {cnt_reg[28:0], 3'b000};
                wr_mask = 4'b1111;
            end
            OP_LEN_HI:
            begin
                wr_en   = 1'b1;
                wr_addr = LEN_HI_WORD;
                wr_data = cnt_reg[60:29];
                wr_mask = 4'b1111;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            for (int l = 0; l < 4; l++)
            begin
                if (wr_mask[l])
                begin
                    blk_reg[wr_addr][8*l +: 8] <= wr_data[8*l +: 8];
                end
            end
        end
    end

    always_comb
    begin
        chain_next     = chain_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        cnt_next       = cnt_reg;
        round_next     = round_reg;
        wcnt_next      = wcnt_reg;
        end_pend_next  = end_pend_reg;
        oidx_next      = oidx_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        word_next      = word_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        unique case (op)
            OP_IDLE:
            begin
                if (in_acc)
                begin
                    end_pend_next = s_axis_tlast;
                    if (s_axis_tuser[0])
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            OP_LOAD:
            begin
                a_next     = chain_reg[0];
                b_next     = chain_reg[1];
                c_next     = chain_reg[2];
                d_next     = chain_reg[3];
                round_next = '0;
            end
            OP_ROUND:
            begin
                a_next     = d_reg;
                b_next     = rot_val;
                c_next     = b_reg;
                d_next     = c_reg;
                round_next = round_reg + 1'b1;
            end
            OP_ADD:
            begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
            end
            OP_PADB:
            begin
                wcnt_next = {1'b0, pos_word} + 5'd1;
            end
            OP_ZERO:
            begin
                if (!wcnt_reg[4])
                begin
                    wcnt_next = wcnt_reg + 5'd1;
                end
            end
            OP_WCLR:
            begin
                wcnt_next = '0;
            end
            OP_EMIT:
            begin
                if (emit_load)
                begin
                    out_valid_next = 1'b1;
                    word_next      = chain_reg[oidx_reg];
                    idx_next       = oidx_reg;
                    last_next      = (oidx_reg == 2'd3);
                    oidx_next      = oidx_reg + 2'd1;
                end
            end
            OP_INIT:
            begin
                chain_next    = MD4_IV;
                cnt_next      = '0;
                end_pend_next = 1'b0;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg     <= MD4_IV;
            cnt_reg       <= '0;
            round_reg     <= '0;
            wcnt_reg      <= '0;
            end_pend_reg  <= 1'b0;
            oidx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            chain_reg     <= chain_next;
            cnt_reg       <= cnt_next;
            round_reg     <= round_next;
            wcnt_reg      <= wcnt_next;
            end_pend_reg  <= end_pend_next;
            oidx_reg      <= oidx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        d_reg    <= d_next;
        word_reg <= word_next;
        idx_reg  <= idx_next;
        last_reg <= last_next;
    end

    `MD4_ASSERT_NEXT(a_round_to_add, op == OP_ROUND && round_reg == LAST_ROUND, op == OP_ADD, "compression did not finish after the last round")
    `MD4_ASSERT_NEXT(a_emit_to_init, emit_load && oidx_reg == 2'd3, op == OP_INIT, "engine did not reinitialize after the last digest word")
    `MD4_ASSERT_IMPL(a_wcnt_range, 1'b1, wcnt_reg <= 5'd16, "padding word counter out of range")
    `MD4_ASSERT_IMPL(a_last_tag, m_axis_tvalid, m_axis_tlast == (m_axis_tuser == 2'd3), "last flag does not match word index")

endmodule
